@@ design/yfvr_pkg.sv @@
// yfvr_pkg: widths, fixed-point constants and the arctangent table for the
// yaw frame velocity rotation block; used by yfvr_cordic and the top level.
// no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package yfvr_pkg;

  // turn size in encoder counts (a power of two) and velocity width
  localparam int COUNTS_PER_TURN = 8192;
  localparam int VEL_WIDTH       = 16;

  // field widths
  localparam int YAW_W = 14;
  localparam int OUT_W = 17;

  // fixed-point format and cordic depth
  localparam int FRAC         = 18;
  localparam int CORDIC_STEPS = 18;
  localparam int STEP_IW      = $clog2(CORDIC_STEPS);

  localparam int TWO_PI_Q18      = 1647099;
  localparam int PI_Q18          = 823550;
  localparam int PI_HALF_Q18     = 411775;
  localparam int CORDIC_GAIN_Q18 = 159189;

  // cordic vector and angle width: one sign bit plus headroom over unity
  localparam int CW = FRAC + 3;
  localparam int ZW = FRAC + 3;

  // packed stream widths, whole bytes
  localparam int IN_DW  = ((YAW_W + 2 * VEL_WIDTH + 7) / 8) * 8;
  localparam int OUT_DW = ((2 * OUT_W + 7) / 8) * 8;

  // data that travels beside the angle through the cordic
  typedef struct packed {
    logic                        flip;
    logic signed [VEL_WIDTH-1:0] vx;
    logic signed [VEL_WIDTH-1:0] vy;
  } yfvr_side_t;

  // atan(2^-i) in q18, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q18(input logic [STEP_IW-1:0] idx);
    logic signed [ZW-1:0] val;
    case (idx)
      5'd0:    val = ZW'(205887);
      5'd1:    val = ZW'(121542);
      5'd2:    val = ZW'(64220);
      5'd3:    val = ZW'(32599);
      5'd4:    val = ZW'(16363);
      5'd5:    val = ZW'(8189);
      5'd6:    val = ZW'(4096);
      5'd7:    val = ZW'(2048);
      5'd8:    val = ZW'(1024);
      5'd9:    val = ZW'(512);
      5'd10:   val = ZW'(256);
      5'd11:   val = ZW'(128);
      5'd12:   val = ZW'(64);
      5'd13:   val = ZW'(32);
      5'd14:   val = ZW'(16);
      5'd15:   val = ZW'(8);
      5'd16:   val = ZW'(4);
      5'd17:   val = ZW'(2);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

@@ design/yfvr_cordic.sv @@
// yfvr_cordic: rotation-mode cordic, one register stage per step, giving
// cos and sin of a q18 angle in the range of a quarter turn either way.
// depends on yfvr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yfvr_cordic (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  en,
  input  wire                                  in_valid,
  input  wire logic signed [yfvr_pkg::ZW-1:0]  in_z,
  input  wire yfvr_pkg::yfvr_side_t            in_side,
  output logic                                 out_valid,
  output logic signed [yfvr_pkg::CW-1:0]       out_cos,
  output logic signed [yfvr_pkg::CW-1:0]       out_sin,
  output yfvr_pkg::yfvr_side_t                 out_side
);
  import yfvr_pkg::*;

  // index 0 is the stage input, index i+1 the register after step i
  logic                 v_r    [0:CORDIC_STEPS];
  logic signed [CW-1:0] x_r    [0:CORDIC_STEPS];
  logic signed [CW-1:0] y_r    [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r    [0:CORDIC_STEPS];
  yfvr_side_t           side_r [0:CORDIC_STEPS];

  // start vector: gain-corrected unity on the x axis
  assign v_r[0]    = in_valid;
  assign x_r[0]    = CW'(CORDIC_GAIN_Q18);
  assign y_r[0]    = '0;
  assign z_r[0]    = in_z;
  assign side_r[0] = in_side;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CW-1:0] x_nxt;
    logic signed [CW-1:0] y_nxt;
    logic signed [ZW-1:0] z_nxt;

    // one micro-rotation towards zero residual angle
    always_comb begin
      if (z_r[i] >= 0) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - atan_q18(STEP_IW'(i));
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + atan_q18(STEP_IW'(i));
      end
    end

    // stage register, held while the pipeline stalls
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_valid = v_r[CORDIC_STEPS];
  assign out_cos   = x_r[CORDIC_STEPS];
  assign out_sin   = y_r[CORDIC_STEPS];
  assign out_side  = side_r[CORDIC_STEPS];

endmodule

`default_nettype wire

@@ design/yaw_frame_velocity_rotation.sv @@
// yaw_frame_velocity_rotation: turns a gimbal-frame velocity into the chassis
// frame by the yaw error; depends on yfvr_pkg and yfvr_cordic.
//
// usage
//   in_*  : one transfer carries yaw_error, gimbal_vx and gimbal_vy; the
//           error is wrapped by a full turn toward zero past half a turn,
//           scaled to a q18 angle and folded into a quarter turn either way
//   out_* : one transfer per input carries chassis_vx = cos*x - sin*y and
//           chassis_vy = sin*x + cos*y, truncated toward zero, saturated
//   pipeline: 4 angle stages, 18 cordic steps, 4 product and rounding
//           stages and the output register lie between the input transfer
//           and out_tvalid
//   throughput: one item per cycle when not stalled; every stage is a plain
//           register, the rate set by the one-step-per-stage cordic pipeline
//   stall: when out_tready is low the result waits in the output register,
//           one more item is caught in a skid register, and only then does
//           in_tready drop and the whole pipeline hold; nothing is dropped
//   reset: rst_n low clears every valid bit; payload registers keep stale
//           values that are never shown
`timescale 1ns / 1ps
`default_nettype none

module yaw_frame_velocity_rotation (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // fields from bit 0: yaw_error, gimbal_vx, gimbal_vy, zero fill
  input  wire [yfvr_pkg::IN_DW-1:0]      in_tdata,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // fields from bit 0: chassis_vx, chassis_vy, zero fill
  output logic [yfvr_pkg::OUT_DW-1:0]    out_tdata
);
  import yfvr_pkg::*;

  localparam int CPT_LOG2 = $clog2(COUNTS_PER_TURN);
  // wrapped error width: holds the input and a full turn added to it
  localparam int EW  = ((YAW_W > CPT_LOG2 + 1) ? YAW_W : CPT_LOG2 + 1) + 1;
  localparam int TPW = $clog2(TWO_PI_Q18 + 1) + 1;
  localparam int PW  = EW + TPW;
  localparam int MW  = CW + VEL_WIDTH;
  localparam int SW  = MW + 1;

  localparam logic signed [EW-1:0]  HALF_E    = EW'(COUNTS_PER_TURN / 2);
  localparam logic signed [EW-1:0]  TURN_E    = EW'(COUNTS_PER_TURN);
  localparam logic signed [TPW-1:0] TWO_PI_C  = TPW'(TWO_PI_Q18);
  localparam logic signed [PW-1:0]  CPT_BIAS  = PW'(COUNTS_PER_TURN - 1);
  localparam logic signed [ZW-1:0]  PI_HALF_Z = ZW'(PI_HALF_Q18);
  localparam logic signed [ZW-1:0]  PI_Z      = ZW'(PI_Q18);
  localparam logic signed [SW-1:0]  FRAC_BIAS = SW'((1 << FRAC) - 1);
  localparam logic signed [SW-1:0]  OUT_MAX   = SW'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [SW-1:0]  OUT_MIN   = -SW'(1 << (OUT_W - 1));

  logic en;

  // input field unpacking
  logic signed [YAW_W-1:0]     yaw_in;
  logic signed [VEL_WIDTH-1:0] vx_in;
  logic signed [VEL_WIDTH-1:0] vy_in;

  assign yaw_in = $signed(in_tdata[YAW_W-1:0]);
  assign vx_in  = $signed(in_tdata[YAW_W+VEL_WIDTH-1:YAW_W]);
  assign vy_in  = $signed(in_tdata[YAW_W+2*VEL_WIDTH-1:YAW_W+VEL_WIDTH]);

  // stage 1: wrap the error by a full turn toward zero
  logic signed [EW-1:0] e_ext;
  logic signed [EW-1:0] e_nxt;
  logic signed [EW-1:0] e1_r;
  logic                 v1_r;
  yfvr_side_t           side1_r;

  always_comb begin
    e_ext = EW'(yaw_in);
    if (e_ext > HALF_E) begin
      e_nxt = e_ext - TURN_E;
    end else if (e_ext < -HALF_E) begin
      e_nxt = e_ext + TURN_E;
    end else begin
      e_nxt = e_ext;
    end
  end

  // stage 2: scale counts by two pi in q18
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] prod2_r;
  logic                 v2_r;
  yfvr_side_t           side2_r;

  assign prod_nxt = PW'(e1_r) * PW'(TWO_PI_C);

  // stage 3: divide by the turn size, truncating toward zero
  logic signed [PW-1:0] prod_adj;
  logic signed [ZW-1:0] theta_nxt;
  logic signed [ZW-1:0] theta3_r;
  logic                 v3_r;
  yfvr_side_t           side3_r;

  always_comb begin
    prod_adj  = prod2_r + (prod2_r[PW-1] ? CPT_BIAS : '0);
    theta_nxt = ZW'(prod_adj >>> CPT_LOG2);
  end

  // stage 4: fold into a quarter turn either way, noting the half-turn flip
  logic signed [ZW-1:0] z_nxt;
  logic                 flip_nxt;
  logic signed [ZW-1:0] z4_r;
  logic                 v4_r;
  yfvr_side_t           side4_r;

  always_comb begin
    if (theta3_r > PI_HALF_Z) begin
      z_nxt    = theta3_r - PI_Z;
      flip_nxt = 1'b1;
    end else if (theta3_r < -PI_HALF_Z) begin
      z_nxt    = theta3_r + PI_Z;
      flip_nxt = 1'b1;
    end else begin
      z_nxt    = theta3_r;
      flip_nxt = 1'b0;
    end
  end

  // front-end stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    if (en) begin
      e1_r         <= e_nxt;
      side1_r.flip <= 1'b0;
      side1_r.vx   <= vx_in;
      side1_r.vy   <= vy_in;
      prod2_r      <= prod_nxt;
      side2_r      <= side1_r;
      theta3_r     <= theta_nxt;
      side3_r      <= side2_r;
      z4_r         <= z_nxt;
      side4_r.flip <= flip_nxt;
      side4_r.vx   <= side3_r.vx;
      side4_r.vy   <= side3_r.vy;
    end
  end

  // cordic: cos and sin of the folded angle
  logic                 cv;
  logic signed [CW-1:0] ccos;
  logic signed [CW-1:0] csin;
  yfvr_side_t           cside;

  yfvr_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_z      (z4_r),
    .in_side   (side4_r),
    .out_valid (cv),
    .out_cos   (ccos),
    .out_sin   (csin),
    .out_side  (cside)
  );

  // back-end stage registers: flip, products, sums, rounding
  logic                        vn_r;
  logic signed [CW-1:0]        cos_n_r;
  logic signed [CW-1:0]        sin_n_r;
  logic signed [VEL_WIDTH-1:0] vx_n_r;
  logic signed [VEL_WIDTH-1:0] vy_n_r;
  logic                        vm_r;
  logic signed [MW-1:0]        cx_m_r;
  logic signed [MW-1:0]        sy_m_r;
  logic signed [MW-1:0]        sx_m_r;
  logic signed [MW-1:0]        cy_m_r;
  logic                        vs_r;
  logic signed [SW-1:0]        sum_x_r;
  logic signed [SW-1:0]        sum_y_r;
  logic                        vr_r;
  logic signed [OUT_W-1:0]     rx_r;
  logic signed [OUT_W-1:0]     ry_r;

  // truncate toward zero by the fraction, then clamp to the output range
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] adj;
    logic signed [SW-1:0] q;
    logic signed [OUT_W-1:0] r;
    adj = s + (s[SW-1] ? FRAC_BIAS : '0);
    q   = adj >>> FRAC;
    if (q > OUT_MAX) begin
      r = OUT_MAX[OUT_W-1:0];
    end else if (q < OUT_MIN) begin
      r = OUT_MIN[OUT_W-1:0];
    end else begin
      r = q[OUT_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn_r <= 1'b0;
      vm_r <= 1'b0;
      vs_r <= 1'b0;
      vr_r <= 1'b0;
    end else if (en) begin
      vn_r <= cv;
      vm_r <= vn_r;
      vs_r <= vm_r;
      vr_r <= vs_r;
    end
    if (en) begin
      cos_n_r <= cside.flip ? -ccos : ccos;
      sin_n_r <= cside.flip ? -csin : csin;
      vx_n_r  <= cside.vx;
      vy_n_r  <= cside.vy;
      cx_m_r  <= MW'(cos_n_r) * MW'(vx_n_r);
      sy_m_r  <= MW'(sin_n_r) * MW'(vy_n_r);
      sx_m_r  <= MW'(sin_n_r) * MW'(vx_n_r);
      cy_m_r  <= MW'(cos_n_r) * MW'(vy_n_r);
      sum_x_r <= SW'(cx_m_r) - SW'(sy_m_r);
      sum_y_r <= SW'(sx_m_r) + SW'(cy_m_r);
      rx_r    <= round_sat(sum_x_r);
      ry_r    <= round_sat(sum_y_r);
    end
  end

  // output register and skid register
  logic [OUT_DW-1:0] pipe_data;
  logic [OUT_DW-1:0] out_data_r;
  logic [OUT_DW-1:0] skid_data_r;
  logic              out_v_r;
  logic              skid_v_r;
  logic              load_out;
  logic              load_skid;

  assign pipe_data = {{(OUT_DW - 2 * OUT_W){1'b0}}, ry_r, rx_r};
  assign en        = !skid_v_r;
  assign load_out  = en && vr_r && (!out_v_r || out_tready);
  assign load_skid = en && vr_r && out_v_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r && out_tready) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else if (load_out) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (load_skid) begin
        skid_v_r <= 1'b1;
      end
    end
    if (skid_v_r && out_tready) begin
      out_data_r <= skid_data_r;
    end else if (load_out) begin
      out_data_r <= pipe_data;
    end
    if (load_skid) begin
      skid_data_r <= pipe_data;
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // the skid register only holds an item behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register empty");

  // the skid register fills only when the receiver stalled a waiting result
  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid register filled without a stall");

  // the folded angle stays within a quarter turn either way
  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> ((z4_r <= PI_HALF_Z) && (z4_r >= -PI_HALF_Z)))
    else $error("folded angle outside the cordic range");

endmodule

`default_nettype wire
